// File: rtl/multi_channel_servo_pwm_core_macros.svh
// Assertion helpers for the servo pulse generator.
// Each assumes signals named clk and arst_n in the scope of use.
`ifndef MULTI_CHANNEL_SERVO_PWM_CORE_MACROS_SVH
`define MULTI_CHANNEL_SERVO_PWM_CORE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define MCSP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define MCSP_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mcsp_pkg.sv
package mcsp_pkg;

	// input item kinds
	localparam logic [1:0] ACT_SERIAL = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_FRAME  = 2'd2;

	// serial command byte fields
	localparam int SEL_BIT  = 7;
	localparam int CTRL_BIT = 6;
	localparam logic [7:0] CMD_STOP  = 8'h40;
	localparam logic [7:0] CMD_START = 8'h41;

	localparam int CHAN_W  = 5;
	localparam int WIDTH_W = 6;
	localparam int COUNT_W = 8;
	localparam int PINS_W  = 32;

	// command queue geometry
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_SELECT,
		OP_STOP,
		OP_START,
		OP_WIDTH,
		OP_TICK,
		OP_FRAME
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [WIDTH_W-1:0]  arg;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// power-on pulse widths: channels 8 to 11 start with a preset
	function automatic logic [WIDTH_W-1:0] reset_width(input int ch);
		logic [WIDTH_W-1:0] w;
		w = '0;
		case (ch)
			8:       w = 6'd10;
			9:       w = 6'd15;
			10:      w = 6'd20;
			11:      w = 6'd20;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/mcsp_in_if.sv
interface mcsp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;

	modport source(output valid, output action, output rx_byte, input ready);
	modport sink(input valid, input action, input rx_byte, output ready);
endinterface

// File: rtl/mcsp_out_if.sv
interface mcsp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pins;
	logic        running;
	logic [4:0]  selected_channel;

	modport source(output valid, output pins, output running, output selected_channel,
		input ready);
	modport sink(input valid, input pins, input running, input selected_channel,
		output ready);
endinterface

// File: rtl/mcsp_front.sv
module mcsp_front (
	mcsp_in_if.sink          item,
	input  mcsp_pkg::q_stat_t q_stat,
	output logic             push_valid,
	output mcsp_pkg::cmd_t   push_cmd
);

	assign item.ready = !q_stat.full;
	assign push_valid = item.valid && !q_stat.full;

	// classify the item into one back-end operation
	always_comb begin
		push_cmd.op  = mcsp_pkg::OP_NOP;
		push_cmd.arg = '0;
		unique case (item.action)
			mcsp_pkg::ACT_SERIAL: begin
				if (item.rx_byte[mcsp_pkg::SEL_BIT]) begin
					push_cmd.op  = mcsp_pkg::OP_SELECT;
					push_cmd.arg = {1'b0, item.rx_byte[mcsp_pkg::CHAN_W-1:0]};
				end else if (item.rx_byte[mcsp_pkg::CTRL_BIT]) begin
					if (item.rx_byte == mcsp_pkg::CMD_STOP)
						push_cmd.op = mcsp_pkg::OP_STOP;
					else if (item.rx_byte == mcsp_pkg::CMD_START)
						push_cmd.op = mcsp_pkg::OP_START;
				end else begin
					push_cmd.op  = mcsp_pkg::OP_WIDTH;
					push_cmd.arg = item.rx_byte[mcsp_pkg::WIDTH_W-1:0];
				end
			end
			mcsp_pkg::ACT_TICK:  push_cmd.op = mcsp_pkg::OP_TICK;
			mcsp_pkg::ACT_FRAME: push_cmd.op = mcsp_pkg::OP_FRAME;
			default:             push_cmd.op = mcsp_pkg::OP_NOP;
		endcase
	end

endmodule

// File: rtl/mcsp_queue.sv
module mcsp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  mcsp_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output mcsp_pkg::cmd_t    head,
	output mcsp_pkg::q_stat_t q_stat
);

	mcsp_pkg::cmd_t                  mem_q [mcsp_pkg::QDEPTH];
	logic [mcsp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [mcsp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [mcsp_pkg::QCNT_W-1:0]     count_q;
	logic                            do_pop;

	assign q_stat.full  = (count_q == mcsp_pkg::QCNT_W'(mcsp_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_valid)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push_valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/mcsp_back.sv
module mcsp_back #(
	parameter int CHANNELS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mcsp_pkg::cmd_t cmd,
	output logic           pop,
	mcsp_out_if.source     result
);

	logic [mcsp_pkg::WIDTH_W-1:0] width_q [CHANNELS];
	logic [mcsp_pkg::COUNT_W-1:0] cnt_q;
	logic [mcsp_pkg::CHAN_W-1:0]  sel_q;
	logic                         en_q;
	logic [mcsp_pkg::PINS_W-1:0]  pins_q;
	logic                         valid_q;
	logic [CHANNELS-1:0]          hit;

	// the state registers double as the result register
	assign pop                     = q_valid && (!valid_q || result.ready);
	assign result.valid            = valid_q;
	assign result.pins             = pins_q;
	assign result.running          = en_q;
	assign result.selected_channel = sel_q;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		assign hit[i] = {2'b00, width_q[i]} > cnt_q;
	end

	// write the width of the selected channel; a select beyond the last channel hits none
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				width_q[i] <= mcsp_pkg::reset_width(i);
			end
		end else if (pop && cmd.op == mcsp_pkg::OP_WIDTH) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (sel_q == mcsp_pkg::CHAN_W'(i))
					width_q[i] <= cmd.arg;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sel_q   <= '0;
			en_q    <= 1'b1;
			pins_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				unique case (cmd.op)
					mcsp_pkg::OP_SELECT: sel_q <= cmd.arg[mcsp_pkg::CHAN_W-1:0];
					mcsp_pkg::OP_STOP:   en_q  <= 1'b0;
					mcsp_pkg::OP_START:  en_q  <= 1'b1;
					mcsp_pkg::OP_TICK: begin
						if (en_q) begin
							pins_q <= mcsp_pkg::PINS_W'(hit);
							cnt_q  <= cnt_q + 1'b1;
						end
					end
					mcsp_pkg::OP_FRAME: begin
						if (en_q)
							cnt_q <= '0;
					end
					default: ;
				endcase
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/multi_channel_servo_pwm_core.sv
// Flow: an accepted item is put in a two-entry command queue that separates the
// decoder from the channel state, then applied to the state registers, which serve
// as the result register. Throughput: one item per cycle while results are taken.
// Reset (arst_n low, asynchronous): generator running, channel 0 selected, tick count
// and pins clear, all widths zero except channels 8 to 11 at 10, 15, 20 and 20.
`include "multi_channel_servo_pwm_core_macros.svh"

module multi_channel_servo_pwm_core #(
	parameter int CHANNELS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mcsp_in_if.sink    item,
	mcsp_out_if.source result
);

	// pin bits that belong to a real channel
	localparam logic [31:0] PIN_MASK = 32'((64'd1 << CHANNELS) - 64'd1);

	mcsp_pkg::q_stat_t q_stat;
	mcsp_pkg::cmd_t    push_cmd;
	mcsp_pkg::cmd_t    q_head;
	logic              push_valid;
	logic              q_pop;
	logic [31:0]       ghost_pins;
	logic              stop_tick;

	// Front: take each item and turn it into one operation (select, stop, start,
	// width, tick, frame or nothing). Hold input ready low only while the queue is full.
	mcsp_front u_front (
		.item       (item),
		.q_stat     (q_stat),
		.push_valid (push_valid),
		.push_cmd   (push_cmd)
	);

	// Queue: buffer decoded operations so that a stalled result does not stop intake
	// at once.
	mcsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.pop        (q_pop),
		.head       (q_head),
		.q_stat     (q_stat)
	);

	// Back: apply one operation per cycle to the channel state and present the state
	// that follows as the result item. Advance only when the result slot is free.
	mcsp_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!q_stat.empty),
		.cmd     (q_head),
		.pop     (q_pop),
		.result  (result)
	);

	// pin bits outside the channel range, and a tick applied while stopped
	assign ghost_pins = result.pins & ~PIN_MASK;
	assign stop_tick  = q_pop && q_head.op == mcsp_pkg::OP_TICK && !result.running;

	// Pins of absent channels never rise.
	`MCSP_ASSERT_ALWAYS(a_no_ghost_pins, ghost_pins == 32'd0, "absent channel pin high")

	// The queue cannot be full and empty at once.
	`MCSP_ASSERT_ALWAYS(a_queue_state, !(q_stat.full && q_stat.empty), "queue full and empty")

	// Every applied operation produces a result item in the next cycle.
	`MCSP_ASSERT_NEXT(a_pop_result, q_pop, result.valid, "applied operation gave no item")

	// A tick while stopped leaves the pins as they were.
	`MCSP_ASSERT_NEXT(a_stopped_tick, stop_tick, $stable(result.pins), "stopped tick moved pins")

endmodule
